@@ sv/tpgd_pkg.sv @@
`default_nettype none

package tpgd_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CODE_W   = 4;
   localparam int unsigned BRIGHT_W = 8;
   localparam int unsigned EFFECT_W = 3;
   localparam int unsigned CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASELINE_PAD0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASELINE_PAD1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_DELTA     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_TIME       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOTH_HOLD_TIME  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS_STEP = 3'd5;

   // register reset values
   localparam logic [SAMPLE_W-1:0] PRESS_DELTA_RST     = 16'd10;
   localparam logic [SAMPLE_W-1:0] HOLD_TIME_RST       = 16'd300;
   localparam logic [SAMPLE_W-1:0] BOTH_HOLD_TIME_RST  = 16'd400;
   localparam logic [BRIGHT_W-1:0] BRIGHTNESS_STEP_RST = 8'd16;

   // state reset values
   localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST = 8'd128;
   localparam logic [EFFECT_W-1:0] EFFECT_RST     = 3'd1;

   // command kinds
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_DIGIT  = 1'b1;

   // spell codes
   localparam logic [CODE_W-1:0] CODE_EFFECT_MIN = 4'd1;
   localparam logic [CODE_W-1:0] CODE_EFFECT_MAX = 4'd4;
   localparam logic [CODE_W-1:0] CODE_DIM        = 4'd7;
   localparam logic [CODE_W-1:0] CODE_BRIGHTEN   = 4'd8;
   localparam logic [CODE_W-1:0] CODE_DIGIT_MAX  = 4'd9;
   localparam logic [CODE_W-1:0] CODE_TEMPO      = 4'd10;
   localparam logic [CODE_W-1:0] CODE_SHOOT      = 4'd12;

   localparam logic [EFFECT_W-1:0] EFFECT_CYCLE_MAX = 3'd3;
   localparam logic [EFFECT_W-1:0] EFFECT_FIRST     = 3'd1;
   localparam logic [BRIGHT_W-1:0] BRIGHTNESS_MIN   = 8'd1;
   localparam logic [BRIGHT_W-1:0] BRIGHTNESS_MAX   = 8'd255;

   typedef struct packed {
      logic [CODE_W-1:0]   spell_code;
      logic [BRIGHT_W-1:0] brightness_now;
      logic [EFFECT_W-1:0] effect_now;
      logic                tempo_fast_now;
      logic                last_of_run;
   } result_type;

   function automatic logic pad_pressed(input logic [SAMPLE_W-1:0] base,
                                        input logic [SAMPLE_W-1:0] sample,
                                        input logic [SAMPLE_W-1:0] delta);
      logic [SAMPLE_W-1:0] drop;
      drop = (sample < base) ? (base - sample) : '0;
      return drop >= delta;
   endfunction

   function automatic logic [BRIGHT_W-1:0] dim_level(input logic [BRIGHT_W-1:0] b,
                                                     input logic [BRIGHT_W-1:0] step);
      return (b > step) ? (b - step) : BRIGHTNESS_MIN;
   endfunction

   function automatic logic [BRIGHT_W-1:0] brighten_level(input logic [BRIGHT_W-1:0] b,
                                                          input logic [BRIGHT_W-1:0] step);
      logic [BRIGHT_W:0] sum;
      sum = {1'b0, b} + {1'b0, step};
      return sum[BRIGHT_W] ? BRIGHTNESS_MAX : sum[BRIGHT_W-1:0];
   endfunction

   function automatic result_type make_result(input logic [CODE_W-1:0]   code,
                                              input logic [BRIGHT_W-1:0] b,
                                              input logic [EFFECT_W-1:0] e,
                                              input logic                t);
      result_type r;
      r.spell_code     = code;
      r.brightness_now = b;
      r.effect_now     = e;
      r.tempo_fast_now = t;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/two_pad_touch_gesture_decoder.sv @@
// Two-pad touch gesture decoder. Each req item is either a pair of pad samples with a
// millisecond time stamp, or a direct spell digit. Sample items update press, hold and
// both-held tracking and give zero, one or two rsp items (dim, brighten, shoot, or a tap
// on pad 0 and/or pad 1); a digit item gives one rsp item, or none for digits above 9.
// All decoding is done in the cycle an item is accepted, so an item can be taken every
// clock while req_stall is low; results wait in a two-entry output queue. req_stall rises
// when that queue cannot take two more results in the current cycle, so the item after
// one that gave two results waits until a result has left the queue. Time differences
// wrap modulo 2^32. Registers are written through the csr port (always ready); indexes
// above 5 are ignored, and writes are meant to happen only while the block is idle.
`default_nettype none

module two_pad_touch_gesture_decoder
   import tpgd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic                 req_command,
   input  wire logic [SAMPLE_W-1:0]  req_sample_pad0,
   input  wire logic [SAMPLE_W-1:0]  req_sample_pad1,
   input  wire logic [TIME_W-1:0]    req_time_ms,
   input  wire logic [CODE_W-1:0]    req_digit,

   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [CODE_W-1:0]    rsp_spell_code,
   output      logic [BRIGHT_W-1:0]  rsp_brightness_now,
   output      logic [EFFECT_W-1:0]  rsp_effect_now,
   output      logic                 rsp_tempo_fast_now,
   output      logic                 rsp_last_of_run,

   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SAMPLE_W-1:0]  csr_data
);

   // configuration
   logic [SAMPLE_W-1:0] baseline_pad0_ff, baseline_pad1_ff, press_delta_ff;
   logic [SAMPLE_W-1:0] hold_time_ff, both_hold_time_ff;
   logic [BRIGHT_W-1:0] brightness_step_ff;

   // gesture state
   logic                pad0_pressed_ff, pad1_pressed_ff;
   logic                pad0_held_ff, pad1_held_ff, both_armed_ff;
   logic [TIME_W-1:0]   pad0_start_ff, pad1_start_ff, both_start_ff;
   logic [BRIGHT_W-1:0] brightness_ff;
   logic [EFFECT_W-1:0] effect_ff;
   logic                tempo_fast_ff;

   logic                pad0_held_in, pad1_held_in, both_armed_in;
   logic [TIME_W-1:0]   pad0_start_in, pad1_start_in, both_start_in;
   logic [BRIGHT_W-1:0] brightness_in;
   logic [EFFECT_W-1:0] effect_in;
   logic                tempo_fast_in;

   // output queue
   result_type          q_ff [2];
   result_type          q0_in, q1_in;
   logic [1:0]          count_ff, count_in, count_left;

   logic                accept, pop;
   logic                p0, p1, w0, w1, both, was_both;
   logic [1:0]          n_res;
   result_type          res0, res1;
   logic [EFFECT_W-1:0] effect_next;

   assign csr_ready = 1'b1;
   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign req_stall = (count_ff == 2'd2) || ((count_ff == 2'd1) && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign p0       = pad_pressed(baseline_pad0_ff, req_sample_pad0, press_delta_ff);
   assign p1       = pad_pressed(baseline_pad1_ff, req_sample_pad1, press_delta_ff);
   assign w0       = pad0_pressed_ff;
   assign w1       = pad1_pressed_ff;
   assign both     = p0 && p1;
   assign was_both = w0 && w1;

   always_comb begin
      pad0_held_in  = pad0_held_ff;
      pad1_held_in  = pad1_held_ff;
      both_armed_in = both_armed_ff;
      pad0_start_in = pad0_start_ff;
      pad1_start_in = pad1_start_ff;
      both_start_in = both_start_ff;
      brightness_in = brightness_ff;
      effect_in     = effect_ff;
      tempo_fast_in = tempo_fast_ff;
      effect_next   = effect_ff;
      n_res         = 2'd0;
      res0          = '0;
      res1          = '0;

      if (req_command == CMD_DIGIT) begin
         if (req_digit <= CODE_DIGIT_MAX) begin
            if (req_digit >= CODE_EFFECT_MIN && req_digit <= CODE_EFFECT_MAX) begin
               effect_in = req_digit[EFFECT_W-1:0];
            end
            if (req_digit == CODE_DIM) begin
               brightness_in = dim_level(brightness_ff, brightness_step_ff);
            end else if (req_digit == CODE_BRIGHTEN) begin
               brightness_in = brighten_level(brightness_ff, brightness_step_ff);
            end
            res0  = make_result(req_digit, brightness_in, effect_in, tempo_fast_in);
            n_res = 2'd1;
         end
      end else begin
         if (p0 && !w0) begin
            pad0_start_in = req_time_ms;
            pad0_held_in  = 1'b0;
         end
         if (p1 && !w1) begin
            pad1_start_in = req_time_ms;
            pad1_held_in  = 1'b0;
         end
         if (both && !was_both) begin
            both_start_in = req_time_ms;
            both_armed_in = 1'b1;
         end
         if (p0 && !pad0_held_in
             && (req_time_ms - pad0_start_in) >= {16'd0, hold_time_ff}) begin
            pad0_held_in = 1'b1;
         end
         if (p1 && !pad1_held_in
             && (req_time_ms - pad1_start_in) >= {16'd0, hold_time_ff}) begin
            pad1_held_in = 1'b1;
         end

         // dim, brighten and shoot exclude each other, as do they and the taps
         if (!p1 && w1 && p0 && pad0_held_in && !pad1_held_in) begin
            brightness_in = dim_level(brightness_ff, brightness_step_ff);
            res0  = make_result(CODE_DIM, brightness_in, effect_in, tempo_fast_in);
            n_res = 2'd1;
         end else if (!p0 && w0 && p1 && pad1_held_in && !pad0_held_in) begin
            brightness_in = brighten_level(brightness_ff, brightness_step_ff);
            res0  = make_result(CODE_BRIGHTEN, brightness_in, effect_in, tempo_fast_in);
            n_res = 2'd1;
         end else if (both && both_armed_in
                      && (req_time_ms - both_start_in) >= {16'd0, both_hold_time_ff}) begin
            res0          = make_result(CODE_SHOOT, brightness_in, effect_in, tempo_fast_in);
            n_res         = 2'd1;
            both_armed_in = 1'b0;
         end else if (!both) begin
            if (!p0 && w0 && !pad0_held_in && !p1) begin
               effect_next = effect_ff + 3'd1;
               if (effect_next > EFFECT_CYCLE_MAX) begin
                  effect_next = EFFECT_FIRST;
               end
               effect_in = effect_next;
               res0  = make_result({1'b0, effect_next}, brightness_in, effect_in,
                                   tempo_fast_in);
               n_res = 2'd1;
            end
            if (!p1 && w1 && !pad1_held_in && !p0) begin
               tempo_fast_in = !tempo_fast_ff;
               if (n_res == 2'd0) begin
                  res0 = make_result(CODE_TEMPO, brightness_in, effect_in, tempo_fast_in);
               end else begin
                  res1 = make_result(CODE_TEMPO, brightness_in, effect_in, tempo_fast_in);
               end
               n_res = n_res + 2'd1;
            end
         end

         if (!both && was_both) begin
            both_armed_in = 1'b0;
         end
      end

      if (n_res == 2'd2) begin
         res1.last_of_run = 1'b1;
      end else begin
         res0.last_of_run = 1'b1;
      end
   end

   // queue: shift on pop, then append new results behind what is left
   always_comb begin
      count_left = count_ff - {1'b0, pop};
      if (pop) begin
         q0_in = q_ff[1];
      end else begin
         q0_in = q_ff[0];
      end
      q1_in    = q_ff[1];
      count_in = count_left;
      if (accept && n_res != 2'd0) begin
         if (count_left == 2'd0) begin
            q0_in = res0;
            q1_in = res1;
         end else begin
            q1_in = res0;
         end
         count_in = count_left + n_res;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad0_pressed_ff <= 1'b0;
         pad1_pressed_ff <= 1'b0;
         pad0_held_ff    <= 1'b0;
         pad1_held_ff    <= 1'b0;
         both_armed_ff   <= 1'b0;
         pad0_start_ff   <= '0;
         pad1_start_ff   <= '0;
         both_start_ff   <= '0;
         brightness_ff   <= BRIGHTNESS_RST;
         effect_ff       <= EFFECT_RST;
         tempo_fast_ff   <= 1'b0;
      end else if (accept) begin
         if (req_command == CMD_SAMPLE) begin
            pad0_pressed_ff <= p0;
            pad1_pressed_ff <= p1;
         end
         pad0_held_ff  <= pad0_held_in;
         pad1_held_ff  <= pad1_held_in;
         both_armed_ff <= both_armed_in;
         pad0_start_ff <= pad0_start_in;
         pad1_start_ff <= pad1_start_in;
         both_start_ff <= both_start_in;
         brightness_ff <= brightness_in;
         effect_ff     <= effect_in;
         tempo_fast_ff <= tempo_fast_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_pad0_ff   <= '0;
         baseline_pad1_ff   <= '0;
         press_delta_ff     <= PRESS_DELTA_RST;
         hold_time_ff       <= HOLD_TIME_RST;
         both_hold_time_ff  <= BOTH_HOLD_TIME_RST;
         brightness_step_ff <= BRIGHTNESS_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BASELINE_PAD0:   baseline_pad0_ff   <= csr_data;
            REG_BASELINE_PAD1:   baseline_pad1_ff   <= csr_data;
            REG_PRESS_DELTA:     press_delta_ff     <= csr_data;
            REG_HOLD_TIME:       hold_time_ff       <= csr_data;
            REG_BOTH_HOLD_TIME:  both_hold_time_ff  <= csr_data;
            REG_BRIGHTNESS_STEP: brightness_step_ff <= csr_data[BRIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = (count_ff != 2'd0);
   assign rsp_spell_code     = q_ff[0].spell_code;
   assign rsp_brightness_now = q_ff[0].brightness_now;
   assign rsp_effect_now     = q_ff[0].effect_now;
   assign rsp_tempo_fast_now = q_ff[0].tempo_fast_now;
   assign rsp_last_of_run    = q_ff[0].last_of_run;

endmodule

`default_nettype wire
